FILE: sv/midpoint_quadratic_curve_smoother_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint quadratic curve smoother
// Implication checks, same cycle and next cycle; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_QUADRATIC_CURVE_SMOOTHER_CORE_DEFINES_SVH
`define MIDPOINT_QUADRATIC_CURVE_SMOOTHER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MQCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqcs: same-cycle check failed");
`define MQCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqcs: next-cycle check failed");
`else
`define MQCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MQCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/mqcs_pkg.sv
// ----------------------------------------------------------------------------
// mqcs_pkg
// Shared types and constants of the midpoint quadratic curve smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package mqcs_pkg;

  localparam logic [15:0] STEP_RESET = 16'd6554;
  localparam logic [15:0] STEP_MIN   = 16'd2048;
  localparam logic [16:0] T_ONE      = 17'h10000;

  localparam logic [1:0] WSEL_P0 = 2'd0;
  localparam logic [1:0] WSEL_P1 = 2'd1;
  localparam logic [1:0] WSEL_P2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LOAD,
    ST_WGT,
    ST_MAC,
    ST_PUT,
    ST_COMMIT
  } mqcs_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic sel_b;
    logic wgt_en;
    logic mac_en;
    logic put;
    logic run_end;
    logic advance_t;
    logic commit;
  } mqcs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic held_valid;
    logic fin;
    logic wgt_last;
    logic mac_last;
    logic curve_last;
    logic out_free;
  } mqcs_status_t;

endpackage

`default_nettype wire

FILE: sv/mqcs_vertex_if.sv
// ----------------------------------------------------------------------------
// mqcs_vertex_if
// Vertex stream: valid/ready with x, y and final flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqcs_vertex_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          final_vertex;

  modport source (output valid, output vertex_x, output vertex_y,
                  output final_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y,
                input final_vertex, output ready);
endinterface

`default_nettype wire

FILE: sv/mqcs_point_if.sv
// ----------------------------------------------------------------------------
// mqcs_point_if
// Sample stream: valid/ready with x, y and run end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqcs_point_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          run_end;

  modport source (output valid, output point_x, output point_y,
                  output run_end, input ready);
  modport sink (input valid, input point_x, input point_y,
                input run_end, output ready);
endinterface

`default_nettype wire

FILE: sv/mqcs_ctrl.sv
// ----------------------------------------------------------------------------
// mqcs_ctrl
// Sequencer: per vertex up to two curves, per sample weights, MAC, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mqcs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mqcs_pkg::mqcs_status_t status,
  output mqcs_pkg::mqcs_cmd_t         cmd
);

  mqcs_pkg::mqcs_state_t state_r, state_nxt;
  logic                  sel_b_r, sel_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mqcs_pkg::ST_IDLE;
      sel_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_b_r <= sel_b_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_b_nxt = sel_b_r;
    case (state_r)
      mqcs_pkg::ST_IDLE: begin
        if (status.in_valid) state_nxt = mqcs_pkg::ST_DECIDE;
      end
      mqcs_pkg::ST_DECIDE: begin
        if (status.held_valid) begin
          sel_b_nxt = 1'b0;
          state_nxt = mqcs_pkg::ST_LOAD;
        end else if (status.fin) begin
          sel_b_nxt = 1'b1;
          state_nxt = mqcs_pkg::ST_LOAD;
        end else begin
          state_nxt = mqcs_pkg::ST_COMMIT;
        end
      end
      mqcs_pkg::ST_LOAD: state_nxt = mqcs_pkg::ST_WGT;
      mqcs_pkg::ST_WGT: begin
        if (status.wgt_last) state_nxt = mqcs_pkg::ST_MAC;
      end
      mqcs_pkg::ST_MAC: begin
        if (status.mac_last) state_nxt = mqcs_pkg::ST_PUT;
      end
      mqcs_pkg::ST_PUT: begin
        if (status.out_free) begin
          if (!status.curve_last) begin
            state_nxt = mqcs_pkg::ST_WGT;
          end else if (!sel_b_r && status.fin) begin
            sel_b_nxt = 1'b1;
            state_nxt = mqcs_pkg::ST_LOAD;
          end else begin
            state_nxt = mqcs_pkg::ST_COMMIT;
          end
        end
      end
      mqcs_pkg::ST_COMMIT: state_nxt = mqcs_pkg::ST_IDLE;
      default: state_nxt = mqcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel_b     = sel_b_r;
    cmd.run_end   = status.curve_last && (sel_b_r || !status.fin);
    case (state_r)
      mqcs_pkg::ST_IDLE:   cmd.in_ready = 1'b1;
      mqcs_pkg::ST_DECIDE: ;
      mqcs_pkg::ST_LOAD:   cmd.load = 1'b1;
      mqcs_pkg::ST_WGT:    cmd.wgt_en = 1'b1;
      mqcs_pkg::ST_MAC:    cmd.mac_en = 1'b1;
      mqcs_pkg::ST_PUT: begin
        cmd.put       = status.out_free;
        cmd.advance_t = status.out_free && !status.curve_last;
      end
      mqcs_pkg::ST_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mqcs_datapath.sv
// ----------------------------------------------------------------------------
// mqcs_datapath
// Vertex history, curve points, Bezier weights, chunked MAC, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqcs_datapath #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  mqcs_vertex_if.sink                 in_vtx,
  mqcs_point_if.source                out_pt,
  input  wire logic                   cfg_we,
  input  wire logic [15:0]            cfg_wdata,
  input  wire mqcs_pkg::mqcs_cmd_t    cmd,
  output mqcs_pkg::mqcs_status_t      status
);

  localparam int W     = COORD_WIDTH;
  localparam int NCH   = (W + 15) / 16;
  localparam int PAD_W = NCH * 16;
  localparam int CI_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ACC_W = W + 33;
  localparam logic [W-1:0]     SIGN_MASK = W'(1) << (W - 1);
  localparam logic [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << 31;
  localparam logic [CI_W-1:0]  CI_LAST   = CI_W'(NCH - 1);

  logic [15:0]      tstep_r;
  logic [W-1:0]     vx_r, vy_r;
  logic             fin_r;
  logic [W-1:0]     older_x_r, older_y_r, held_x_r, held_y_r;
  logic             older_v_r, held_v_r;
  logic [W-1:0]     p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r;
  logic [15:0]      t_r;
  logic [1:0]       wi_r;
  logic [CI_W-1:0]  ci_r;
  logic [32:0]      w0_r, w1_r, w2_r;
  logic [ACC_W-1:0] accx_r, accy_r;
  logic [W-1:0]     outx_r, outy_r;
  logic             out_end_r, out_valid_r;

  logic [15:0] step;
  logic [16:0] t_sum;
  logic [16:0] u;
  logic [16:0] ma, mb;
  logic [33:0] wprod;
  logic [W:0]  s_oh_x, s_oh_y, s_hv_x, s_hv_y;
  logic [W-1:0] m_oh_x, m_oh_y, m_hv_x, m_hv_y;
  logic [32:0]  wsel;
  logic [W-1:0] psel_x, psel_y;
  logic [PAD_W-1:0] pad_x, pad_y;
  logic [15:0]  ch_x, ch_y;
  logic [48:0]  prod_x, prod_y;
  logic         out_free;

  assign step  = (tstep_r < mqcs_pkg::STEP_MIN) ? mqcs_pkg::STEP_MIN : tstep_r;
  assign t_sum = {1'b0, t_r} + {1'b0, step};
  assign u     = mqcs_pkg::T_ONE - {1'b0, t_r};

  assign s_oh_x = {1'b0, older_x_r} + {1'b0, held_x_r};
  assign s_oh_y = {1'b0, older_y_r} + {1'b0, held_y_r};
  assign s_hv_x = {1'b0, held_x_r} + {1'b0, vx_r};
  assign s_hv_y = {1'b0, held_y_r} + {1'b0, vy_r};
  assign m_oh_x = s_oh_x[W:1];
  assign m_oh_y = s_oh_y[W:1];
  assign m_hv_x = s_hv_x[W:1];
  assign m_hv_y = s_hv_y[W:1];

  // weight phase: u*u, t*u, t*t through one multiplier
  always_comb begin
    case (wi_r)
      mqcs_pkg::WSEL_P0: begin ma = u;              mb = u;              end
      mqcs_pkg::WSEL_P1: begin ma = {1'b0, t_r};    mb = u;              end
      default:           begin ma = {1'b0, t_r};    mb = {1'b0, t_r};    end
    endcase
  end
  assign wprod = ma * mb;

  always_comb begin
    case (wi_r)
      mqcs_pkg::WSEL_P0: begin wsel = w0_r; psel_x = p0x_r; psel_y = p0y_r; end
      mqcs_pkg::WSEL_P1: begin wsel = w1_r; psel_x = p1x_r; psel_y = p1y_r; end
      default:           begin wsel = w2_r; psel_x = p2x_r; psel_y = p2y_r; end
    endcase
  end
  assign pad_x  = PAD_W'(psel_x);
  assign pad_y  = PAD_W'(psel_y);
  assign ch_x   = pad_x[ci_r*16 +: 16];
  assign ch_y   = pad_y[ci_r*16 +: 16];
  assign prod_x = wsel * ch_x;
  assign prod_y = wsel * ch_y;

  assign out_free = !out_valid_r || out_pt.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstep_r     <= mqcs_pkg::STEP_RESET;
      older_v_r   <= 1'b0;
      held_v_r    <= 1'b0;
      wi_r        <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tstep_r <= cfg_wdata;

      if (cmd.commit) begin
        if (fin_r) begin
          older_v_r <= 1'b0;
          held_v_r  <= 1'b0;
        end else begin
          older_v_r <= held_v_r;
          held_v_r  <= 1'b1;
        end
      end

      if (cmd.load) begin
        wi_r <= '0;
        ci_r <= '0;
      end else if (cmd.wgt_en) begin
        wi_r <= (wi_r == mqcs_pkg::WSEL_P2) ? '0 : wi_r + 2'd1;
      end else if (cmd.mac_en) begin
        if (ci_r == CI_LAST) begin
          ci_r <= '0;
          wi_r <= (wi_r == mqcs_pkg::WSEL_P2) ? '0 : wi_r + 2'd1;
        end else begin
          ci_r <= ci_r + CI_W'(1);
        end
      end

      if (cmd.put) out_valid_r <= 1'b1;
      else if (out_pt.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vtx.valid && in_vtx.ready) begin
      vx_r  <= W'(in_vtx.vertex_x) ^ SIGN_MASK;
      vy_r  <= W'(in_vtx.vertex_y) ^ SIGN_MASK;
      fin_r <= in_vtx.final_vertex;
    end

    if (cmd.commit && !fin_r) begin
      older_x_r <= held_x_r;
      older_y_r <= held_y_r;
      held_x_r  <= vx_r;
      held_y_r  <= vy_r;
    end

    if (cmd.load) begin
      t_r <= '0;
      if (!cmd.sel_b) begin
        p0x_r <= older_v_r ? m_oh_x : held_x_r;
        p0y_r <= older_v_r ? m_oh_y : held_y_r;
        p1x_r <= held_x_r;
        p1y_r <= held_y_r;
        p2x_r <= m_hv_x;
        p2y_r <= m_hv_y;
      end else begin
        p0x_r <= held_v_r ? m_hv_x : vx_r;
        p0y_r <= held_v_r ? m_hv_y : vy_r;
        p1x_r <= vx_r;
        p1y_r <= vy_r;
        p2x_r <= vx_r;
        p2y_r <= vy_r;
      end
    end else if (cmd.advance_t) begin
      t_r <= t_sum[15:0];
    end

    if (cmd.wgt_en) begin
      accx_r <= ACC_HALF;
      accy_r <= ACC_HALF;
      case (wi_r)
        mqcs_pkg::WSEL_P0: w0_r <= wprod[32:0];
        mqcs_pkg::WSEL_P1: w1_r <= {wprod[31:0], 1'b0};
        default:           w2_r <= wprod[32:0];
      endcase
    end else if (cmd.mac_en) begin
      accx_r <= accx_r + (ACC_W'(prod_x) << {ci_r, 4'b0000});
      accy_r <= accy_r + (ACC_W'(prod_y) << {ci_r, 4'b0000});
    end

    if (cmd.put) begin
      outx_r    <= accx_r[W+31:32] ^ SIGN_MASK;
      outy_r    <= accy_r[W+31:32] ^ SIGN_MASK;
      out_end_r <= cmd.run_end;
    end
  end

  assign in_vtx.ready   = cmd.in_ready;
  assign out_pt.valid   = out_valid_r;
  assign out_pt.point_x = $signed(outx_r);
  assign out_pt.point_y = $signed(outy_r);
  assign out_pt.run_end = out_end_r;

  always_comb begin
    status            = '0;
    status.in_valid   = in_vtx.valid;
    status.held_valid = held_v_r;
    status.fin        = fin_r;
    status.wgt_last   = (wi_r == mqcs_pkg::WSEL_P2);
    status.mac_last   = (wi_r == mqcs_pkg::WSEL_P2) && (ci_r == CI_LAST);
    status.curve_last = t_sum[16];
    status.out_free   = out_free;
  end

endmodule

`default_nettype wire

FILE: sv/midpoint_quadratic_curve_smoother_core.sv
// Sequence: accept, a decide state, then per curve a load state and per sample
//   the weight states, the MAC states over the coordinate chunks and an output state.
// Throughput: one vertex at a time; samples are paced by the shared weight and
//   MAC multipliers, and wait in the output state while the output is stalled.
// Reset: synchronous active-low rst_n clears history, sequencer and output
//   valid; t_step returns to 6554.
// ----------------------------------------------------------------------------
// midpoint_quadratic_curve_smoother_core
// Quadratic Bezier smoothing of a polyline through vertex midpoints.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_quadratic_curve_smoother_core_defines.svh"

module midpoint_quadratic_curve_smoother_core #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mqcs_vertex_if.sink      in_vtx,
  mqcs_point_if.source     out_pt,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  mqcs_pkg::mqcs_cmd_t    cmd;
  mqcs_pkg::mqcs_status_t status;

  mqcs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  mqcs_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (in_vtx),
    .out_pt    (out_pt),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

  `MQCS_ASSERT_NEXT(a_one_vertex, clk, rst_n, in_vtx.valid && in_vtx.ready, !in_vtx.ready)
  `MQCS_ASSERT_IMPLY(a_load_cause, clk, rst_n, cmd.load, status.held_valid || status.fin)
  `MQCS_ASSERT_NEXT(a_commit_idle, clk, rst_n, cmd.commit, in_vtx.ready)

endmodule

`default_nettype wire
